[hdl/odi_pkg.sv]
// ----------------------------------------------------------------------------
// odi_pkg
// shared types, codes and constants of the mecanum odometry integrator
// ----------------------------------------------------------------------------
package odi_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;

  // bits walked by the restoring divider, one per cycle
  localparam int ITER_COUNT = 70;
  localparam int STEP_W     = 7;

  localparam logic [29:0] KINV_Q30    = 30'd652032874;
  localparam logic [29:0] BAM_PER_RAD = 30'd683565276;

  localparam logic [31:0] MPP_RST  = 32'd0;
  localparam logic [31:0] ITS_RST  = 32'd16777216;
  localparam logic [15:0] JUMP_RST = 16'd500;

  typedef enum logic [2:0] {
    ST_FIRST   = 3'd0,
    ST_UPDATED = 3'd1,
    ST_JUMP    = 3'd2,
    ST_ZERO    = 3'd3,
    ST_CLEARED = 3'd4
  } odo_status_t;

  typedef enum logic [1:0] {
    REG_MPP  = 2'd0,
    REG_ITS  = 2'd1,
    REG_JUMP = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_MUL1, S_MUL2, S_MUL3, S_PREP, S_TURN, S_ITER, S_COMMIT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DECIDE, OP_MUL1, OP_MUL2, OP_MUL3, OP_PREP, OP_TURN,
    OP_ITER, OP_COMMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [STEP_W-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic do_update;
    logic out_free;
  } dp_stat_t;

  // arctangent of 2^-i as binary angle
  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[hdl/odi_ctrl.sv]
// ----------------------------------------------------------------------------
// odi_ctrl
// sequencer: walks one request through decide, multiply, iterate and commit
// ----------------------------------------------------------------------------
module odi_ctrl
  import odi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] iter_r, iter_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    in_tready = 1'b0;
    cmd.op    = OP_NONE;
    cmd.step  = iter_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.op    = OP_DECIDE;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        if (stat.do_update) begin
          cmd.op    = OP_MUL1;
          state_nxt = S_MUL2;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_MUL2: begin
        cmd.op    = OP_MUL2;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.op    = OP_MUL3;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.op    = OP_PREP;
        state_nxt = S_TURN;
      end
      S_TURN: begin
        cmd.op    = OP_TURN;
        iter_nxt  = '0;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cmd.op = OP_ITER;
        if (iter_r == STEP_W'(ITER_COUNT - 1)) begin
          state_nxt = S_COMMIT;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.op    = OP_COMMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[hdl/odi_dp.sv]
// ----------------------------------------------------------------------------
// odi_dp
// datapath: registers, pose state, multipliers, cordic, dividers, result reg
// ----------------------------------------------------------------------------
module odi_dp
  import odi_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  dp_cmd_t        cmd,
  output dp_stat_t       stat,
  input  logic [0:0]     in_tuser,
  input  logic [159:0]   in_tdata,
  input  logic           cfg_wr_en,
  input  logic [1:0]     cfg_addr,
  input  logic [31:0]    cfg_wr_data,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [2:0]     out_tuser,
  output logic [191:0]   out_tdata
);

  localparam int SW   = 20;
  localparam int DXW  = 53;
  localparam int AW   = 40;
  localparam int GW   = 46;
  localparam int THW  = 41;
  localparam int DTW  = 62;
  localparam int MAGW = 60;
  localparam int NW   = ITER_COUNT;
  localparam int K    = 34 - FRAC_BITS;
  localparam int DVW  = 32 + K;
  localparam int CW   = 56;
  localparam int ZW   = 34;
  localparam logic signed [CW-1:0] RND_HALF = CW'(1) << (K - 1);

  // configuration
  logic [31:0] mpp_r, its_r;
  logic [15:0] jlim_r;

  // architectural state
  logic        first_r;
  logic [31:0] last_r [4];
  logic [31:0] last_time_r;
  logic [31:0] px_r, py_r, hdg_r;
  logic [31:0] vel_r [3];

  // latched request
  logic        mode_r;
  logic [31:0] cur_r [4];
  logic [31:0] now_r;

  // work registers
  odo_status_t            kind_r;
  logic [31:0]            dt_r;
  logic signed [SW-1:0]   sx_r, sy_r, st_r;
  logic signed [DXW-1:0]  dx_r, dy_r, rx_r, ry_r;
  logic [AW-1:0]          a_r;
  logic [GW-1:0]          gh_r, g_r;
  logic [53:0]            gl_r;
  logic signed [THW-1:0]  thl_r, thh_r;
  logic [49:0]            kxh_r, kyh_r;
  logic [61:0]            kxl_r, kyl_r;
  logic signed [DTW-1:0]  dth_r;
  logic signed [41:0]     tl_r, th_r;
  logic [31:0]            hadd_r;
  logic signed [CW-1:0]   cx_r, cy_r;
  logic signed [ZW-1:0]   cz_r;
  logic [DVW-1:0]         d_r;
  logic [NW-1:0]          num_r [3];
  logic [DVW-1:0]         rem_r [3];
  logic [31:0]            q_r [3];
  logic                   big_r [3];
  logic                   neg_r [3];

  // result register
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [191:0] out_data_r;

  // ---------------- decide ----------------
  logic [31:0] p_w [4];
  logic [31:0] dt_w;
  logic        jump_w;
  odo_status_t kind_w;

  always_comb begin
    jump_w = 1'b0;
    for (int i = 0; i < 4; i++) begin
      p_w[i] = cur_r[i] - last_r[i];
      if ($signed({p_w[i][31], p_w[i]}) > $signed({17'b0, jlim_r}) ||
          $signed({p_w[i][31], p_w[i]}) < -$signed({17'b0, jlim_r})) begin
        jump_w = 1'b1;
      end
    end
    dt_w = now_r - last_time_r;
    if (mode_r)              kind_w = ST_CLEARED;
    else if (first_r)        kind_w = ST_FIRST;
    else if (dt_w == 32'd0)  kind_w = ST_ZERO;
    else if (jump_w)         kind_w = ST_JUMP;
    else                     kind_w = ST_UPDATED;
  end

  // ---------------- multiplies ----------------
  logic signed [DXW-1:0] dx_p, dy_p;
  logic [63:0]           ml_p;
  logic [DXW-1:0]        dxm_w, dym_w;
  logic [52:0]           rxm_w, rym_w;

  assign dx_p  = $signed(sx_r) * $signed({1'b0, mpp_r});
  assign dy_p  = $signed(sy_r) * $signed({1'b0, mpp_r});
  assign ml_p  = mpp_r * its_r;
  assign dxm_w = dx_r[DXW-1] ? DXW'(-dx_r) : DXW'(dx_r);
  assign dym_w = dy_r[DXW-1] ? DXW'(-dy_r) : DXW'(dy_r);
  assign rxm_w = {1'b0, kxh_r, 2'b00} + 53'(kxl_r[61:30]);
  assign rym_w = {1'b0, kyh_r, 2'b00} + 53'(kyl_r[61:30]);

  // ---------------- cordic prep ----------------
  logic                 flip_w;
  logic [31:0]          zsrc_w;
  logic [41:0]          tsum_w;

  assign flip_w = ($signed(hdg_r) > $signed(32'h4000_0000)) ||
                  ($signed(hdg_r) < $signed(32'hC000_0000));
  assign zsrc_w = flip_w ? (hdg_r + 32'h8000_0000) : hdg_r;
  assign tsum_w = tl_r + {th_r[20:0], 21'b0} + 42'd512;

  // ---------------- divider prep ----------------
  logic signed [DTW-1:0] vin_w [3];
  logic [MAGW-1:0]       mag_w [3];
  logic [NW-1:0]         numi_w [3];

  always_comb begin
    vin_w[0] = {{(DTW-DXW){dx_r[DXW-1]}}, dx_r};
    vin_w[1] = {{(DTW-DXW){dy_r[DXW-1]}}, dy_r};
    vin_w[2] = dth_r;
    for (int i = 0; i < 3; i++) begin
      mag_w[i]  = vin_w[i][DTW-1] ? MAGW'(-vin_w[i]) : MAGW'(vin_w[i]);
      numi_w[i] = (NW'(mag_w[i]) << 10) - (NW'(mag_w[i]) << 4) - (NW'(mag_w[i]) << 3);
    end
  end

  // ---------------- iteration ----------------
  logic [4:0]           sh_w;
  logic                 cord_on_w;
  logic signed [CW-1:0] xs_w, ys_w;
  logic signed [ZW-1:0] at_w;
  logic [DVW:0]         rsh_w [3];
  logic                 qb_w [3];
  logic [DVW-1:0]       rem_nxt [3];

  assign sh_w      = cmd.step[4:0];
  assign cord_on_w = cmd.step < STEP_W'(CORDIC_STEPS);
  assign xs_w      = cx_r >>> sh_w;
  assign ys_w      = cy_r >>> sh_w;
  assign at_w      = $signed({2'b00, atan_bam(sh_w)});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsh_w[i] = {rem_r[i], num_r[i][NW-1]};
      qb_w[i]  = rsh_w[i] >= {1'b0, d_r};
      rem_nxt[i] = qb_w[i] ? DVW'(rsh_w[i] - {1'b0, d_r}) : rsh_w[i][DVW-1:0];
    end
  end

  // ---------------- commit ----------------
  function automatic logic [31:0] sat32(input logic signed [CW-1:0] v);
    if (v > $signed({{(CW-32){1'b0}}, 32'h7FFF_FFFF}))      return 32'h7FFF_FFFF;
    else if (v < $signed({{(CW-32){1'b1}}, 32'h8000_0000})) return 32'h8000_0000;
    else                                                    return v[31:0];
  endfunction

  logic signed [CW-1:0] rndx_w, rndy_w;
  logic [31:0]          vq_w [3];
  logic [31:0]          px_nxt, py_nxt, hdg_nxt;
  logic [31:0]          vel_nxt [3];
  logic                 big_w;

  assign rndx_w = (cx_r + RND_HALF) >>> K;
  assign rndy_w = (cy_r + RND_HALF) >>> K;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      big_w = big_r[i] | q_r[i][31];
      if (neg_r[i]) vq_w[i] = big_w ? 32'h8000_0000 : (32'd0 - q_r[i]);
      else          vq_w[i] = big_w ? 32'h7FFF_FFFF : q_r[i];
    end
    px_nxt  = px_r;
    py_nxt  = py_r;
    hdg_nxt = hdg_r;
    for (int i = 0; i < 3; i++) vel_nxt[i] = vel_r[i];
    case (kind_r)
      ST_CLEARED: begin
        px_nxt  = '0;
        py_nxt  = '0;
        hdg_nxt = '0;
        for (int i = 0; i < 3; i++) vel_nxt[i] = '0;
      end
      ST_UPDATED: begin
        px_nxt  = sat32($signed({{(CW-32){px_r[31]}}, px_r}) + rndx_w);
        py_nxt  = sat32($signed({{(CW-32){py_r[31]}}, py_r}) + rndy_w);
        hdg_nxt = hdg_r + hadd_r;
        for (int i = 0; i < 3; i++) vel_nxt[i] = vq_w[i];
      end
      default: ;
    endcase
  end

  // ---------------- status ----------------
  assign stat.do_update = (kind_r == ST_UPDATED);
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_data_r;

  // ---------------- state with reset ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpp_r       <= MPP_RST;
      its_r       <= ITS_RST;
      jlim_r      <= JUMP_RST;
      first_r     <= 1'b1;
      last_time_r <= '0;
      px_r        <= '0;
      py_r        <= '0;
      hdg_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) last_r[i] <= '0;
      for (int i = 0; i < 3; i++) vel_r[i] <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_MPP:  mpp_r  <= cfg_wr_data;
          REG_ITS:  its_r  <= cfg_wr_data;
          REG_JUMP: jlim_r <= cfg_wr_data[15:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (cmd.op == OP_COMMIT) begin
        out_valid_r <= 1'b1;
        px_r        <= px_nxt;
        py_r        <= py_nxt;
        hdg_r       <= hdg_nxt;
        for (int i = 0; i < 3; i++) vel_r[i] <= vel_nxt[i];
        if (kind_r == ST_FIRST || kind_r == ST_UPDATED) begin
          first_r     <= 1'b0;
          last_time_r <= now_r;
          for (int i = 0; i < 4; i++) last_r[i] <= cur_r[i];
        end
      end
    end
  end

  // ---------------- work registers ----------------
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        mode_r <= in_tuser[0];
        for (int i = 0; i < 4; i++) cur_r[i] <= in_tdata[32*i +: 32];
        now_r  <= in_tdata[159:128];
      end
      OP_DECIDE: begin
        kind_r <= kind_w;
        dt_r   <= dt_w;
        sx_r   <= p_w[0][SW-1:0] - p_w[1][SW-1:0] - p_w[2][SW-1:0] + p_w[3][SW-1:0];
        sy_r   <= SW'(0) - (p_w[0][SW-1:0] + p_w[1][SW-1:0] + p_w[2][SW-1:0]
                  + p_w[3][SW-1:0]);
        st_r   <= p_w[1][SW-1:0] - p_w[0][SW-1:0] - p_w[2][SW-1:0] + p_w[3][SW-1:0];
      end
      OP_MUL1: begin
        dx_r <= dx_p;
        dy_r <= dy_p;
        a_r  <= ml_p[63:24];
      end
      OP_MUL2: begin
        gh_r  <= a_r[39:24] * BAM_PER_RAD;
        gl_r  <= a_r[23:0] * BAM_PER_RAD;
        thl_r <= $signed(st_r) * $signed({1'b0, a_r[19:0]});
        thh_r <= $signed(st_r) * $signed({1'b0, a_r[39:20]});
        kxh_r <= dxm_w[51:32] * KINV_Q30;
        kxl_r <= dxm_w[31:0] * KINV_Q30;
        kyh_r <= dym_w[51:32] * KINV_Q30;
        kyl_r <= dym_w[31:0] * KINV_Q30;
      end
      OP_MUL3: begin
        g_r   <= gh_r + GW'(gl_r[53:24]);
        dth_r <= {{(DTW-THW){thl_r[THW-1]}}, thl_r} + {thh_r[THW-1], thh_r, 20'b0};
        rx_r  <= dx_r[DXW-1] ? DXW'(-rxm_w) : DXW'(rxm_w);
        ry_r  <= dy_r[DXW-1] ? DXW'(-rym_w) : DXW'(rym_w);
      end
      OP_PREP: begin
        tl_r <= $signed(st_r) * $signed({1'b0, g_r[20:0]});
        th_r <= $signed(st_r) * $signed({1'b0, g_r[41:21]});
        cx_r <= flip_w ? -CW'(rx_r) : CW'(rx_r);
        cy_r <= flip_w ? -CW'(ry_r) : CW'(ry_r);
        cz_r <= {{(ZW-32){zsrc_w[31]}}, zsrc_w};
        d_r  <= DVW'(dt_r) << K;
        for (int i = 0; i < 3; i++) begin
          num_r[i] <= numi_w[i];
          neg_r[i] <= vin_w[i][DTW-1];
          rem_r[i] <= '0;
          q_r[i]   <= '0;
          big_r[i] <= 1'b0;
        end
      end
      OP_TURN: hadd_r <= tsum_w[41:10];
      OP_ITER: begin
        if (cord_on_w) begin
          if (!cz_r[ZW-1]) begin
            cx_r <= cx_r - ys_w;
            cy_r <= cy_r + xs_w;
            cz_r <= cz_r - at_w;
          end else begin
            cx_r <= cx_r + ys_w;
            cy_r <= cy_r - xs_w;
            cz_r <= cz_r + at_w;
          end
        end
        for (int i = 0; i < 3; i++) begin
          num_r[i] <= num_r[i] << 1;
          rem_r[i] <= rem_nxt[i];
          q_r[i]   <= {q_r[i][30:0], qb_w[i]};
          big_r[i] <= big_r[i] | q_r[i][31];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_COMMIT) begin
      out_status_r <= kind_r;
      out_data_r   <= {vel_nxt[2], vel_nxt[1], vel_nxt[0], hdg_nxt, py_nxt, px_nxt};
    end
  end

endmodule

[hdl/mecanum_odometry_integrator.sv]
// ----------------------------------------------------------------------------
// mecanum_odometry_integrator
// dead-reckoning pose and velocity from four mecanum wheel encoders
// ----------------------------------------------------------------------------
//
//  channel | dir | bus                         | contents
//  --------+-----+-----------------------------+----------------------------------
//  in_     | in  | tvalid/tready/tdata/tuser   | four wheel counts, time, mode
//  out_    | out | tvalid/tready/tdata/tuser   | status, pose, body velocities
//  cfg_    | in  | wr_en/addr/wr_data          | meters per pulse, track, jump limit
//
//  an encoder request that updates the pose runs from accept to result through
//  decide, the multiply steps, prep and turn, then the divider iterations (one
//  quotient bit each, cordic micro-rotations run alongside) and commit, which
//  waits for a free result register; clear, first, zero-interval and jump requests
//  skip the multiply and divider steps; one request is in work at a time; the next
//  request can be accepted while the previous result waits on out_tready
//  reset is synchronous, active low; it restores the register defaults,
//  clears the pose and arms first-sample latching
//
module mecanum_odometry_integrator
  import odi_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // count_front_left, count_rear_left, count_front_right, count_rear_right,
  // time_ms
  input  logic [159:0] in_tdata,
  // mode
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, heading, vel_x, vel_y, yaw_rate
  output logic [191:0] out_tdata,
  // status
  output logic [2:0]   out_tuser,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wr_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: one state per datapath step
  odi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: pose state, multipliers, cordic, three dividers, result register
  odi_dp #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata)
  );

endmodule

[hdl/odi_checker.sv]
// ----------------------------------------------------------------------------
// odi_checker
// port-level checks of the odometry integrator
// ----------------------------------------------------------------------------
module odi_checker
  import odi_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [191:0] out_tdata,
  input logic [2:0]   out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a clear result shows a zero pose and zero velocities
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_CLEARED |-> out_tdata == '0)
    else $error("clear result not zero");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // nothing to show right after reset
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_tvalid)
    else $error("result valid out of reset");

endmodule

bind mecanum_odometry_integrator odi_checker u_odi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[bench/mecanum_odometry_integrator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mecanum_odometry_integrator_tb
// self-checking bench: encoder samples and clears go in over the input stream,
// a bit-exact pose and velocity predictor builds the expected results, and
// every returned result is compared field by field in arrival order
// ----------------------------------------------------------------------------
module mecanum_odometry_integrator_tb;
  import odi_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int TURNS = CORDIC_STEPS_DEF;
  localparam longint INV_GAIN = 64'd652032874;
  localparam logic [63:0] RAD_TO_BAM = 64'd683565276;
  // drain time after the last result, a little over the longest request
  localparam int SETTLE_CYCLES = 100;

  // arctangent of 2^-i as a binary angle
  localparam longint ARC_TABLE [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861};

  typedef struct packed {
    logic              mode;
    logic [3:0][31:0]  cnt;   // front left, rear left, front right, rear right
    logic [31:0]       t_ms;
  } odo_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] hd;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] wz;
  } odo_res_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [159:0] in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         cfg_wr_en;
  logic [1:0]   cfg_addr;
  logic [31:0]  cfg_wr_data;

  mecanum_odometry_integrator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wr_data(cfg_wr_data)
  );

  // predictor copy of the block's registers and state
  logic [31:0] mpp_q;
  logic [31:0] track_q;
  logic [15:0] limit_q;
  logic        first_pend;
  logic [31:0] base_cnt [4];
  logic [31:0] base_time;
  logic [31:0] pose_x_q;
  logic [31:0] pose_y_q;
  logic [31:0] pose_hd_q;
  logic [31:0] vel_q [3];

  odo_res_t expected_poses [$];
  int       err_count;
  bit       idle_on;
  int       hold_len;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // limit on the whole run
  initial begin
    #10ms;
    $display("mecanum_odometry_integrator_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- arithmetic
  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint to_q_frac(input longint v);
    return (v + (64'sd1 <<< (33 - FRAC))) >>> (34 - FRAC);
  endfunction

  // multiply by the inverse cordic gain, truncating toward zero
  function automatic longint gain_comp(input longint v);
    logic [63:0] mag;
    logic [63:0] r;
    mag = (v < 0) ? -v : v;
    r = (((mag >> 32) * INV_GAIN) << 2) + (((mag & 64'hffffffff) * INV_GAIN) >> 30);
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  // product with 1000 can pass 64 bits, so the division runs at 128 bits
  function automatic logic [31:0] rate_of(input longint delta, input logic [31:0] dt);
    logic [63:0]  mag;
    logic [127:0] quo;
    logic [63:0]  q;
    mag = (delta < 0) ? -delta : delta;
    quo = ({64'd0, mag} * 128'd1000) / ({96'd0, dt} << (34 - FRAC));
    q = (quo > (128'd1 << 33)) ? (64'd1 << 33) : quo[63:0];
    return (delta < 0) ? clamp32(-longint'(q)) : clamp32(longint'(q));
  endfunction

  // body vector to world frame by the heading
  function automatic void rotate_to_world(inout longint x, inout longint y,
                                          input logic [31:0] ang);
    longint z;
    longint xs;
    longint ys;
    z = longint'($signed(ang));
    // beyond a quarter turn: flip the vector and take the half-turn angle
    if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30)) begin
      x = -x;
      y = -y;
      z = longint'($signed(ang + 32'h80000000));
    end
    for (int i = 0; i < TURNS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ARC_TABLE[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ARC_TABLE[i];
      end
    end
  endfunction

  // ---------------------------------------------------------------- predictor
  task automatic predict_pose(input odo_req_t r);
    odo_res_t    e;
    longint      p [4];
    logic [31:0] diff;
    logic [31:0] dt;
    bit          jump;
    longint      sx, sy, st, dx, dy, dth, rx, ry;
    logic [63:0] a, g, turn;
    dt = r.t_ms - base_time;
    if (r.mode) begin
      pose_x_q = '0;
      pose_y_q = '0;
      pose_hd_q = '0;
      vel_q = '{default: '0};
      e.status = ST_CLEARED;
    end else if (first_pend) begin
      for (int i = 0; i < 4; i++) base_cnt[i] = r.cnt[i];
      base_time = r.t_ms;
      first_pend = 1'b0;
      e.status = ST_FIRST;
    end else if (dt == 32'd0) begin
      e.status = ST_ZERO;
    end else begin
      jump = 1'b0;
      for (int i = 0; i < 4; i++) begin
        diff = r.cnt[i] - base_cnt[i];
        p[i] = longint'($signed(diff));
        if (p[i] > longint'(limit_q) || p[i] < -longint'(limit_q)) jump = 1'b1;
      end
      if (jump) begin
        e.status = ST_JUMP;
      end else begin
        sx = p[0] - p[1] - p[2] + p[3];
        sy = -(p[0] + p[1] + p[2] + p[3]);
        st = -p[0] + p[1] - p[2] + p[3];
        dx = sx * longint'(mpp_q);
        dy = sy * longint'(mpp_q);
        a = ({32'd0, mpp_q} * {32'd0, track_q}) >> 24;
        g = (a >> 24) * RAD_TO_BAM + (((a & 64'hffffff) * RAD_TO_BAM) >> 24);
        dth = st * longint'(a);
        rx = gain_comp(dx);
        ry = gain_comp(dy);
        for (int i = 0; i < 4; i++) base_cnt[i] = r.cnt[i];
        base_time = r.t_ms;
        rotate_to_world(rx, ry, pose_hd_q);
        pose_x_q = clamp32(longint'($signed(pose_x_q)) + to_q_frac(rx));
        pose_y_q = clamp32(longint'($signed(pose_y_q)) + to_q_frac(ry));
        turn = (64'(st) * g + 64'd512) >> 10;
        pose_hd_q = pose_hd_q + turn[31:0];
        vel_q[0] = rate_of(dx, dt);
        vel_q[1] = rate_of(dy, dt);
        vel_q[2] = rate_of(dth, dt);
        e.status = ST_UPDATED;
      end
    end
    e.px = pose_x_q;
    e.py = pose_y_q;
    e.hd = pose_hd_q;
    e.vx = vel_q[0];
    e.vy = vel_q[1];
    e.wz = vel_q[2];
    expected_poses.push_back(e);
  endtask

  // ---------------------------------------------------------------- drivers
  // one request; valid stays high after the accept until the next gap
  task automatic send_request(input odo_req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tdata <= {r.t_ms, r.cnt[3], r.cnt[2], r.cnt[1], r.cnt[0]};
    in_tuser <= r.mode;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_pose(r);
  endtask

  // stop sending and wait until every result is back and the block is quiet
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all three registers, only while the block is idle
  task automatic set_config(input logic [31:0] mpp, input logic [31:0] trk,
                            input logic [15:0] lim);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_addr <= REG_MPP;
    cfg_wr_data <= mpp;
    @(posedge clk);
    cfg_addr <= REG_ITS;
    cfg_wr_data <= trk;
    @(posedge clk);
    cfg_addr <= REG_JUMP;
    cfg_wr_data <= {16'd0, lim};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mpp_q = mpp;
    track_q = trk;
    limit_q = lim;
  endtask

  function automatic odo_req_t make_req(input bit mode, input logic [31:0] c0,
                                        input logic [31:0] c1, input logic [31:0] c2,
                                        input logic [31:0] c3, input logic [31:0] t);
    odo_req_t r;
    r.mode = mode;
    r.cnt[0] = c0;
    r.cnt[1] = c1;
    r.cnt[2] = c2;
    r.cnt[3] = c3;
    r.t_ms = t;
    return r;
  endfunction

  // sample built from the current baselines: mostly a well-formed step,
  // the rest clears, jumps, repeated times and raw noise
  function automatic odo_req_t random_sample();
    odo_req_t r;
    int       pick;
    int       lim;
    int       wheel;
    lim = limit_q;
    pick = $urandom_range(0, 99);
    r.mode = 1'b0;
    for (int i = 0; i < 4; i++)
      r.cnt[i] = base_cnt[i] + 32'($urandom_range(0, 2 * lim) - lim);
    r.t_ms = base_time + (($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 50));
    if (pick < 4) begin
      r.mode = 1'b1;
      for (int i = 0; i < 4; i++) r.cnt[i] = $urandom;
    end else if (pick < 10) begin
      wheel = $urandom_range(0, 3);
      if ($urandom_range(0, 1))
        r.cnt[wheel] = base_cnt[wheel] + 32'(lim + 1 + $urandom_range(0, 1000));
      else
        r.cnt[wheel] = base_cnt[wheel] - 32'(lim + 1 + $urandom_range(0, 1000));
    end else if (pick < 14) begin
      r.t_ms = base_time;
    end else if (pick < 17) begin
      for (int i = 0; i < 4; i++) r.cnt[i] = $urandom;
      r.t_ms = $urandom;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- receiver
  // random stalls, plus one long hold-off when a test asks for it
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t mismatch %s: expected %h got %h", $time, what, want, got);
    err_count++;
  endtask

  // result checker, oldest expectation first
  always @(posedge clk) begin
    odo_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_poses.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, {29'd0, out_tuser});
      end else begin
        e = expected_poses.pop_front();
        if (out_tuser != e.status) report_mismatch("status", e.status, out_tuser);
        if (out_tdata[31:0] != e.px) report_mismatch("pos_x", e.px, out_tdata[31:0]);
        if (out_tdata[63:32] != e.py) report_mismatch("pos_y", e.py, out_tdata[63:32]);
        if (out_tdata[95:64] != e.hd) report_mismatch("heading", e.hd, out_tdata[95:64]);
        if (out_tdata[127:96] != e.vx) report_mismatch("vel_x", e.vx, out_tdata[127:96]);
        if (out_tdata[159:128] != e.vy)
          report_mismatch("vel_y", e.vy, out_tdata[159:128]);
        if (out_tdata[191:160] != e.wz)
          report_mismatch("yaw_rate", e.wz, out_tdata[191:160]);
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // clear before the first sample, latching, zero interval, jump edges, wraps
  task automatic test_directed();
    set_config(32'd2147484, 32'd16777216, 16'd500);
    send_request(make_req(1'b1, 32'hffffffff, 32'h0, 32'haaaaaaaa, 32'h55555555, 32'h0));
    send_request(make_req(1'b0, 32'h7fffff00, 32'h80000010, 32'hffffff00, 32'h0,
                          32'hfffffff0));
    send_request(make_req(1'b0, 32'h7fffff10, 32'h80000020, 32'hffffff10, 32'h10,
                          32'hfffffff0));
    // counts cross the signed wrap, time crosses zero
    send_request(make_req(1'b0, 32'h80000010, 32'h80000030, 32'h00000010, 32'h110,
                          32'h00000004));
    // exactly at the limit is accepted, one past is dropped
    send_request(make_req(1'b0, 32'h80000010 + 500, 32'h80000030 - 500,
                          32'h00000010 + 500, 32'h110 - 500, 32'h0000000a));
    send_request(make_req(1'b0, 32'h80000204 + 501, 32'h80000030 - 500,
                          32'h00000204, 32'h110 - 500, 32'h00000014));
    send_request(make_req(1'b0, 32'h80000204, 32'h80000030 - 500 - 501,
                          32'h00000204, 32'h110 - 500, 32'h00000014));
    // pure turn and pure strafe
    send_request(make_req(1'b0, 32'h80000204 - 400, 32'h80000030 - 100,
                          32'h00000204 - 400, 32'h110 - 100, 32'h00000015));
    send_request(make_req(1'b0, 32'h80000204 - 300, 32'h80000030,
                          32'h00000204 - 300, 32'h110, 32'h7fffffff));
    send_request(make_req(1'b0, 32'h80000204 - 300, 32'h80000030,
                          32'h00000204 - 300, 32'h110, 32'h7fffffff));
    send_request(make_req(1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 32'hffffffff));
    send_request(make_req(1'b0, 32'h80000204 - 200, 32'h80000030 + 100,
                          32'h00000204 - 400, 32'h110 - 100, 32'h80000000));
  endtask

  // mixed well-formed steps and broken samples under one register setting
  task automatic test_random_phase(input int n, input logic [31:0] mpp,
                                   input logic [31:0] trk, input logic [15:0] lim);
    set_config(mpp, trk, lim);
    repeat (n) send_request(random_sample());
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    hold_len = 400;
    repeat (20) send_request(random_sample());
  endtask

  // sender waits for every result before going on
  task automatic test_pause_until_empty();
    repeat (10) send_request(random_sample());
    drain_results();
    repeat (10) send_request(random_sample());
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_wr_en <= 1'b0;
    cfg_addr <= REG_MPP;
    cfg_wr_data <= '0;
    err_count = 0;
    hold_len = 0;
    idle_on = 1'b1;
    mpp_q = MPP_RST;
    track_q = ITS_RST;
    limit_q = JUMP_RST;
    first_pend = 1'b1;
    base_cnt = '{default: '0};
    base_time = '0;
    pose_x_q = '0;
    pose_y_q = '0;
    pose_hd_q = '0;
    vel_q = '{default: '0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_phase(200, 32'd2147484, 32'd83886080, 16'd500);
    test_backpressure();
    test_pause_until_empty();
    test_random_phase(150, 32'hffffffff, 32'hffffffff, 16'hffff);
    test_random_phase(120, 32'd0, 32'd0, 16'd0);
    test_random_phase(150, $urandom, $urandom, 16'($urandom_range(0, 65535)));
    test_random_phase(150, 32'd42949673, 32'd16777216, 16'd2000);
    test_random_phase(120, 32'd4294967, 32'hffffffff, 16'd1);
    // last stretch with neither side idling
    idle_on = 1'b0;
    test_random_phase(200, 32'd8589935, 32'd50331648, 16'd800);

    drain_results();
    if (err_count == 0) begin
      $display("mecanum_odometry_integrator_tb: PASS");
    end else begin
      $display("mecanum_odometry_integrator_tb: FAIL");
    end
    $finish;
  end

endmodule

[mecanum_odometry_integrator.f]
hdl/odi_pkg.sv
hdl/odi_ctrl.sv
hdl/odi_dp.sv
hdl/mecanum_odometry_integrator.sv
hdl/odi_checker.sv
bench/mecanum_odometry_integrator_tb.sv
